// ===== sv/fbpm_pkg.sv =====
// fbpm_pkg: types, command/status structs and coefficient tables for the
// four-band FIR peak meter. No dependencies; imported by every module.

package fbpm_pkg;

   // Tap index carried between controller and datapath (taps up to 31).
   localparam int TAP_IDX_W = 5;
   // Accumulator: 16x16 products summed over at most 31 taps.
   localparam int ACC_W = 38;

   localparam logic [1:0] BAND_LOW      = 2'd0;
   localparam logic [1:0] BAND_HIGH     = 2'd1;
   localparam logic [1:0] BAND_ONE      = 2'd2;
   localparam logic [1:0] BAND_TWO      = 2'd3;

   localparam logic [1:0] CSR_ADC_OFFSET = 2'd0;
   localparam logic [1:0] CSR_LEVEL_ONE  = 2'd1;
   localparam logic [1:0] CSR_LEVEL_TWO  = 2'd2;
   localparam logic [1:0] CSR_LEVEL_THREE = 2'd3;

   localparam logic [9:0]         ADC_OFFSET_RST = 10'd310;
   localparam logic signed [15:0] LEVEL_ONE_RST  = 16'sd1024;
   localparam logic signed [15:0] LEVEL_TWO_RST  = 16'sd2048;
   localparam logic signed [15:0] LEVEL_THREE_RST = 16'sd3072;

   // ceil(2^21 / 10): exact quotient by ten for dividends below 2^18
   localparam logic [17:0] RECIP_TEN = 18'd209716;

   localparam logic signed [15:0] COEF_LOW [0:6] = '{
      16'sd442, 16'sd2571, 16'sd7893, 16'sd10957, 16'sd7893, 16'sd2571, 16'sd442};
   localparam logic signed [15:0] COEF_HIGH [0:6] = '{
      -16'sd262, 16'sd1522, -16'sd4672, 16'sd6824, -16'sd4672, 16'sd1522,
      -16'sd262};
   localparam logic signed [15:0] COEF_BAND_ONE [0:12] = '{
      16'sd2, 16'sd23, 16'sd25, -16'sd754, -16'sd3680, 16'sd258, 16'sd8253,
      16'sd258, -16'sd3680, -16'sd754, 16'sd25, 16'sd23, 16'sd2};
   localparam logic signed [15:0] COEF_BAND_TWO [0:12] = '{
      16'sd2, -16'sd6, -16'sd58, 16'sd757, -16'sd1351, -16'sd3823, 16'sd8959,
      -16'sd3823, -16'sd1351, 16'sd757, -16'sd58, -16'sd6, 16'sd2};

   typedef struct packed {
      logic [9:0] sample;
      logic       display_tick;
   } fbpm_req_type;

   typedef struct packed {
      logic signed [15:0] peak_low;
      logic signed [15:0] peak_high;
      logic signed [15:0] peak_band_one;
      logic signed [15:0] peak_band_two;
      logic [1:0]         level_low;
      logic [1:0]         level_high;
      logic [1:0]         level_band_one;
      logic [1:0]         level_band_two;
   } fbpm_rsp_type;

   typedef struct packed {
      logic                 capture;    // latch the accepted beat
      logic                 load_volt;  // offset, scale, register magnitude
      logic                 acc_clear;
      logic                 mul_en;     // coef * history tap into product reg
      logic                 acc_add;    // accumulate product reg
      logic                 peak_upd;   // round, saturate, update band peak
      logic                 shift;      // push new voltage into history
      logic                 report;     // load result register, clear peaks
      logic [1:0]           band;
      logic [TAP_IDX_W-1:0] tap;
   } fbpm_cmd_type;

   typedef struct packed {
      logic tick;      // captured beat asks for a report
      logic out_busy;  // result register full and stalled
   } fbpm_status_type;

   // Coefficient of a band at a tap; taps past the table are zero.
   function automatic logic signed [15:0] coef_lookup(
      input logic [1:0]           band,
      input logic [TAP_IDX_W-1:0] tap
   );
      logic signed [15:0] c;
      c = '0;
      case (band)
         BAND_LOW: begin
            if (tap < 5'd7) c = COEF_LOW[tap[2:0]];
         end
         BAND_HIGH: begin
            if (tap < 5'd7) c = COEF_HIGH[tap[2:0]];
         end
         BAND_ONE: begin
            if (tap < 5'd13) c = COEF_BAND_ONE[tap[3:0]];
         end
         BAND_TWO: begin
            if (tap < 5'd13) c = COEF_BAND_TWO[tap[3:0]];
         end
         default: begin
            c = '0;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== sv/four_band_fir_peak_meter_unit.sv =====
// four_band_fir_peak_meter_unit: top level of the four-band FIR peak meter.
// Instantiates fbpm_ctrl and fbpm_datapath; depends on fbpm_pkg.
//
// Usage:
//   req channel: one beat per converter sample (10-bit raw reading plus a
//   display tick). req_stall is high while an item is being worked on.
//   rsp channel: one beat only for an item whose display tick is set; it
//   carries the four band peaks (Q3.12) and a 0..3 bar level per band.
//   csr port: single-cycle writes, index 0 ADC offset, 1..3 level thresholds.
//   Write only while the block is idle.
// Sequence per item: a capture step, a scaling step, then for each band its
//   taps (SHORT_TAPS for two bands, LONG_TAPS for the other two) plus a drain
//   and a finish step on the single shared multiply-accumulate unit, and on a
//   tick a report step, which waits while the result register is full and
//   stalled, before req_stall drops again.
// Reset: history and peaks clear to zero, registers take their reset values,
//   the result register empties.
// Stall: the result sits in an output register; the next item is still taken
//   and worked on, and only its own report waits while rsp_stall is high.

module four_band_fir_peak_meter_unit #(
   parameter int LONG_TAPS  = 13,
   parameter int SHORT_TAPS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fbpm_pkg::fbpm_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fbpm_pkg::fbpm_rsp_type rsp_data,
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_write_data
);
   import fbpm_pkg::*;

   fbpm_cmd_type    cmd;     // sequencer -> datapath
   fbpm_status_type status;  // datapath -> sequencer

   fbpm_ctrl #(
      .LONG_TAPS  (LONG_TAPS),
      .SHORT_TAPS (SHORT_TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fbpm_datapath #(
      .LONG_TAPS (LONG_TAPS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

endmodule

// ===== sv/fbpm_ctrl.sv =====
// fbpm_ctrl: sequencer for the peak meter; walks bands and taps, issues
// datapath commands. Depends on fbpm_pkg.

module fbpm_ctrl #(
   parameter int LONG_TAPS  = 13,
   parameter int SHORT_TAPS = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fbpm_pkg::fbpm_status_type status,
   output fbpm_pkg::fbpm_cmd_type    cmd
);
   import fbpm_pkg::*;

   localparam int MAX_TAPS = (LONG_TAPS > SHORT_TAPS) ? LONG_TAPS : SHORT_TAPS;
   localparam int CNT_W = $clog2(MAX_TAPS);
   localparam logic [CNT_W-1:0] LONG_LAST  = CNT_W'(LONG_TAPS - 1);
   localparam logic [CNT_W-1:0] SHORT_LAST = CNT_W'(SHORT_TAPS - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_VOLT   = 3'd1;
   localparam logic [2:0] S_MAC    = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;
   localparam logic [2:0] S_REPORT = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       band_ff, band_in;
   logic [CNT_W-1:0] tap_ff, tap_in;
   logic [CNT_W-1:0] tap_last;

   assign tap_last  = band_ff[1] ? LONG_LAST : SHORT_LAST;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      tap_in   = tap_ff;
      cmd      = '0;
      cmd.band = band_ff;
      cmd.tap  = TAP_IDX_W'(tap_ff);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_VOLT;
            end
         end
         S_VOLT: begin
            cmd.load_volt = 1'b1;
            cmd.acc_clear = 1'b1;
            band_in  = BAND_LOW;
            tap_in   = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_add = (tap_ff != '0);
            if (tap_ff == tap_last) begin
               state_in = S_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            cmd.acc_add = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            cmd.peak_upd  = 1'b1;
            cmd.acc_clear = 1'b1;
            tap_in        = '0;
            if (band_ff == BAND_TWO) begin
               cmd.shift = 1'b1;
               state_in  = status.tick ? S_REPORT : S_IDLE;
            end else begin
               band_in  = band_ff + 1'b1;
               state_in = S_MAC;
            end
         end
         S_REPORT: begin
            if (!status.out_busy) begin
               cmd.report = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         band_ff  <= '0;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         tap_ff   <= tap_in;
      end
   end

   a_report_needs_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.report |-> status.tick)
      else $error("report issued without display tick");

   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> (tap_ff <= tap_last))
      else $error("tap counter past last tap");

   a_last_band_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && band_ff == BAND_TWO) |=>
      (state_ff == S_REPORT || state_ff == S_IDLE))
      else $error("sequence did not end after last band");

   a_shift_once: assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> (state_ff == S_FINISH && band_ff == BAND_TWO))
      else $error("history shifted outside last band finish");

endmodule

// ===== sv/fbpm_datapath.sv =====
// fbpm_datapath: config registers, voltage scaling, sample history, shared
// MAC, band peaks and result register. Depends on fbpm_pkg.

module fbpm_datapath #(
   parameter int LONG_TAPS = 13
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fbpm_pkg::fbpm_cmd_type    cmd,
   output fbpm_pkg::fbpm_status_type status,
   input  fbpm_pkg::fbpm_req_type    req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output fbpm_pkg::fbpm_rsp_type    rsp_data,
   input  logic                      csr_write_en,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_write_data
);
   import fbpm_pkg::*;

   localparam int HIST_W = $clog2(LONG_TAPS);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(16384);

   // configuration
   logic [9:0]         adc_offset_ff;
   logic signed [15:0] lvl_one_ff, lvl_two_ff, lvl_three_ff;

   // captured beat and voltage scaling
   logic [9:0]         sample_ff;
   logic               tick_ff;
   logic [17:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic signed [10:0] diff;
   logic signed [18:0] scaled;
   logic [35:0]        quot_prod;
   logic signed [15:0] volts;

   // history, MAC, peaks
   logic signed [15:0]      hist_ff [LONG_TAPS];
   logic signed [15:0]      hist_rd;
   logic signed [15:0]      coef;
   logic signed [31:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] rounded, quo;
   logic signed [15:0]      filt;
   logic signed [15:0]      peak_ff [4];

   logic         out_valid_ff, out_valid_in;
   fbpm_rsp_type out_ff, out_in;

   function automatic logic [1:0] bar_level(input logic signed [15:0] pk,
                                            input logic signed [15:0] t1,
                                            input logic signed [15:0] t2,
                                            input logic signed [15:0] t3);
      logic [1:0] lv;
      if (pk > t3)      lv = 2'd3;
      else if (pk > t2) lv = 2'd2;
      else if (pk > t1) lv = 2'd1;
      else              lv = 2'd0;
      return lv;
   endfunction

   // v = round((sample - offset) * 13.2), magnitude via reciprocal of ten
   always_comb begin
      diff      = $signed({1'b0, sample_ff}) - $signed({1'b0, adc_offset_ff});
      scaled    = 19'(diff) * 19'sd132;
      neg_in    = scaled[18];
      mag_in    = (scaled[18] ? 18'(-scaled) : 18'(scaled)) + 18'd5;
      quot_prod = 36'(mag_ff) * 36'(RECIP_TEN);
      volts     = neg_ff ? -$signed({1'b0, quot_prod[35:21]})
                         :  $signed({1'b0, quot_prod[35:21]});
   end

   // MAC path
   always_comb begin
      coef    = coef_lookup(cmd.band, cmd.tap);
      hist_rd = (int'(cmd.tap) < LONG_TAPS) ? hist_ff[cmd.tap[HIST_W-1:0]] : '0;
      prod_in = coef * hist_rd;
      acc_in  = acc_ff;
      if (cmd.acc_clear)    acc_in = '0;
      else if (cmd.acc_add) acc_in = acc_ff + ACC_W'(prod_ff);
      rounded = acc_ff + HALF_LSB;
      quo     = rounded >>> 15;
      if (quo > SAT_HI)      filt = 16'sh7fff;
      else if (quo < SAT_LO) filt = -16'sh8000;
      else                   filt = quo[15:0];
   end

   // result register
   always_comb begin
      out_in                = out_ff;
      out_in.peak_low       = peak_ff[BAND_LOW];
      out_in.peak_high      = peak_ff[BAND_HIGH];
      out_in.peak_band_one  = peak_ff[BAND_ONE];
      out_in.peak_band_two  = peak_ff[BAND_TWO];
      out_in.level_low      = bar_level(peak_ff[BAND_LOW], lvl_one_ff, lvl_two_ff,
                                        lvl_three_ff);
      out_in.level_high     = bar_level(peak_ff[BAND_HIGH], lvl_one_ff, lvl_two_ff,
                                        lvl_three_ff);
      out_in.level_band_one = bar_level(peak_ff[BAND_ONE], lvl_one_ff, lvl_two_ff,
                                        lvl_three_ff);
      out_in.level_band_two = bar_level(peak_ff[BAND_TWO], lvl_one_ff, lvl_two_ff,
                                        lvl_three_ff);
      if (cmd.report)                    out_valid_in = 1'b1;
      else if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      else                               out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adc_offset_ff <= ADC_OFFSET_RST;
         lvl_one_ff    <= LEVEL_ONE_RST;
         lvl_two_ff    <= LEVEL_TWO_RST;
         lvl_three_ff  <= LEVEL_THREE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ADC_OFFSET:  adc_offset_ff <= csr_write_data[9:0];
            CSR_LEVEL_ONE:   lvl_one_ff    <= csr_write_data;
            CSR_LEVEL_TWO:   lvl_two_ff    <= csr_write_data;
            CSR_LEVEL_THREE: lvl_three_ff  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_data.sample;
         tick_ff   <= req_data.display_tick;
      end
      if (cmd.load_volt) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (cmd.mul_en) prod_ff <= prod_in;
      acc_ff <= acc_in;
      if (cmd.report) out_ff <= out_in;
   end

   // history and peaks reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LONG_TAPS; i++) hist_ff[i] <= '0;
         for (int b = 0; b < 4; b++) peak_ff[b] <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.shift) begin
            hist_ff[0] <= volts;
            for (int i = 1; i < LONG_TAPS; i++) hist_ff[i] <= hist_ff[i-1];
         end
         if (cmd.peak_upd && filt > peak_ff[cmd.band]) peak_ff[cmd.band] <= filt;
         if (cmd.report) begin
            for (int b = 0; b < 4; b++) peak_ff[b] <= '0;
         end
      end
   end

   assign status.tick     = tick_ff;
   assign status.out_busy = out_valid_ff && rsp_stall;
   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_ff;

endmodule
